### src/swmf_pkg.sv
// Shared constants and types for the sliding window median filter.
package swmf_pkg;

  // Default sizing
  localparam int DefMaxWindow  = 16;
  localparam int DefSampleBits = 16;

  // Configuration register
  localparam int CfgBits     = 5;
  localparam int WindowReset = 5;

  // Control bundle from the sequencer to the ring memory
  typedef struct packed {
    logic re;   // read request at the read address
    logic we;   // write request at the write address
    logic clr;  // drop all entries back to their reset contents
  } ring_ctrl_t;

endpackage

### src/sliding_window_median_filter.sv
// Sliding window median filter: top level, sequencer and result register.
//
// Each request writes its sample over the oldest of the last window_size entries and returns
// the median of the window (for an even size the floored mean of the middle pair; ties are
// ordered by ring position). Every entry keeps its rank next to its sample in one ring memory
// with a single read and a single write port. From accept to the next accept a request passes
// through a read of the replaced entry, a scan of every window entry through the read port
// that corrects each rank and picks out the middle values, and a final step that writes the
// new entry and loads the result register. The result register lets a new request be
// taken while the previous median waits. Reset and each write of window_size
// empty the window to zeros at once (per-entry valid bits, no clearing pass); a written size
// of zero becomes one and a size above MaxWindow becomes MaxWindow.
module sliding_window_median_filter import swmf_pkg::*; #(
  parameter int MaxWindow  = DefMaxWindow,
  parameter int SampleBits = DefSampleBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         window_size_we_i,
  input  logic        [CfgBits-1:0]    window_size_i,
  input  logic                         sample_valid_i,
  output logic                         sample_stall_o,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic                         median_valid_o,
  input  logic                         median_stall_i,
  output logic signed [SampleBits-1:0] median_o
);

  localparam int RankBits = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int NumBits  = $clog2(MaxWindow + 1);
  localparam int ResetN   = (WindowReset > MaxWindow) ? MaxWindow : WindowReset;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RDP  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [NumBits-1:0]          n_q;
  logic [RankBits-1:0]         wp_q;
  logic [RankBits-1:0]         proc_q;
  logic [RankBits-1:0]         cnt_q;
  logic signed [SampleBits-1:0] new_q, old_q, a_q, b_q;
  logic                        out_vld_q;
  logic signed [SampleBits-1:0] med_q;

  ring_ctrl_t                  ring_ctrl;
  logic [RankBits-1:0]         raddr, waddr, wrank;
  logic signed [SampleBits-1:0] wval;
  logic signed [SampleBits-1:0] rd_val;
  logic [RankBits-1:0]         rd_rank;

  logic                        in_acc;
  logic [NumBits-1:0]          proc_nx;
  logic                        more;
  logic                        is_p;
  logic                        gt_old, gt_new, below_new;
  logic [RankBits-1:0]         rank_upd;
  logic [RankBits-1:0]         k_a, k_b;
  logic signed [SampleBits-1:0] a_fin, b_fin;
  logic signed [SampleBits:0]  pair_sum;
  logic signed [SampleBits-1:0] med_fin;
  logic                        out_load;
  logic [NumBits-1:0]          n_sat;

  // Ring memory
  swmf_ring #(
    .MaxWindow (MaxWindow),
    .SampleBits(SampleBits)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .raddr_i(raddr),
    .waddr_i(waddr),
    .wval_i (wval),
    .wrank_i(wrank),
    .rval_o (rd_val),
    .rrank_o(rd_rank)
  );

  // Handshake
  assign sample_stall_o = (state_q != ST_IDLE);
  assign in_acc         = sample_valid_i && (state_q == ST_IDLE);

  // Scan bookkeeping
  assign proc_nx = NumBits'(proc_q) + NumBits'(1);
  assign more    = (proc_nx < n_q);
  assign is_p    = (proc_q == wp_q);

  // Rank correction of a scanned entry: drop the old key, add the new key
  assign gt_old    = (old_q < rd_val) || ((old_q == rd_val) && (wp_q < proc_q));
  assign gt_new    = (new_q < rd_val) || ((new_q == rd_val) && (wp_q < proc_q));
  assign below_new = (rd_val < new_q) || ((rd_val == new_q) && (proc_q < wp_q));
  assign rank_upd  = rd_rank - RankBits'(gt_old) + RankBits'(gt_new);

  // Ranks of the middle values
  assign k_b = RankBits'(n_q >> 1);
  assign k_a = n_q[0] ? k_b : k_b - RankBits'(1);

  // Memory access selection
  always_comb begin
    ring_ctrl.re  = 1'b0;
    ring_ctrl.we  = 1'b0;
    ring_ctrl.clr = window_size_we_i;
    raddr         = wp_q;
    waddr         = proc_q;
    wval          = rd_val;
    wrank         = rank_upd;
    unique case (state_q)
      ST_IDLE: begin
        ring_ctrl.re = in_acc;
        raddr        = wp_q;
      end
      ST_RDP: begin
        ring_ctrl.re = 1'b1;
        raddr        = '0;
      end
      ST_SCAN: begin
        ring_ctrl.re = more;
        raddr        = RankBits'(proc_nx);
        ring_ctrl.we = !is_p;
      end
      ST_FIN: begin
        ring_ctrl.we = 1'b1;
        waddr        = wp_q;
        wval         = new_q;
        wrank        = cnt_q;
      end
      default: begin
        ring_ctrl.re = 1'b0;
      end
    endcase
  end

  // Median of the finished scan
  assign a_fin    = (cnt_q == k_a) ? new_q : a_q;
  assign b_fin    = (cnt_q == k_b) ? new_q : b_q;
  assign pair_sum = {a_fin[SampleBits-1], a_fin} + {b_fin[SampleBits-1], b_fin};
  assign med_fin  = n_q[0] ? b_fin : pair_sum[SampleBits:1];
  assign out_load = (state_q == ST_FIN) && (!out_vld_q || !median_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RDP;
      ST_RDP:  state_d = ST_SCAN;
      ST_SCAN: if (!more) state_d = ST_FIN;
      ST_FIN:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Window size saturation
  always_comb begin
    if (window_size_i == '0) begin
      n_sat = NumBits'(1);
    end else if (int'(window_size_i) > MaxWindow) begin
      n_sat = NumBits'(MaxWindow);
    end else begin
      n_sat = NumBits'(window_size_i);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= NumBits'(ResetN);
      wp_q      <= '0;
      proc_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (window_size_we_i) begin
        n_q  <= n_sat;
        wp_q <= '0;
      end else if (out_load) begin
        wp_q <= (NumBits'(wp_q) + NumBits'(1) == n_q) ? '0 : wp_q + RankBits'(1);
      end
      if (state_q == ST_RDP) begin
        proc_q <= '0;
        cnt_q  <= '0;
      end else if (state_q == ST_SCAN) begin
        proc_q <= RankBits'(proc_nx);
        if (!is_p && below_new) begin
          cnt_q <= cnt_q + RankBits'(1);
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!median_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      new_q <= sample_i;
    end
    if (state_q == ST_RDP) begin
      old_q <= rd_val;
    end
    if ((state_q == ST_SCAN) && !is_p) begin
      if (rank_upd == k_a) a_q <= rd_val;
      if (rank_upd == k_b) b_q <= rd_val;
    end
    if (out_load) begin
      med_q <= med_fin;
    end
  end

  assign median_valid_o = out_vld_q;
  assign median_o       = med_q;

  // Checks
  a_acc_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RDP))
    else $error("accepted request did not start the replaced-entry read");

  a_wp_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NumBits'(wp_q) < n_q)
    else $error("write position outside the window");

  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (NumBits'(proc_q) < n_q))
    else $error("scan index outside the window");

  a_cnt_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> (NumBits'(cnt_q) < n_q))
    else $error("rank of new entry outside the window");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (median_valid_o && (state_q == ST_IDLE)))
    else $error("finished median not presented");

endmodule

### src/swmf_ring.sv
// Ring memory holding each window entry's sample and its current rank.
module swmf_ring import swmf_pkg::*; #(
  parameter int MaxWindow  = DefMaxWindow,
  parameter int SampleBits = DefSampleBits,
  localparam int RankBits  = (MaxWindow > 1) ? $clog2(MaxWindow) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ring_ctrl_t                   ctrl_i,
  input  logic        [RankBits-1:0]   raddr_i,
  input  logic        [RankBits-1:0]   waddr_i,
  input  logic signed [SampleBits-1:0] wval_i,
  input  logic        [RankBits-1:0]   wrank_i,
  output logic signed [SampleBits-1:0] rval_o,
  output logic        [RankBits-1:0]   rrank_o
);

  localparam int EntryBits = SampleBits + RankBits;

  logic [EntryBits-1:0] mem [MaxWindow];
  logic [EntryBits-1:0] rdata_q;
  logic [MaxWindow-1:0] valid_q;
  logic                 rvld_q;
  logic [RankBits-1:0]  ridx_q;

  // Storage array, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[waddr_i] <= {wval_i, wrank_i};
    end
    if (ctrl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Per-entry valid bits; an unwritten entry is a zero sample ranked by its index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
      ridx_q  <= '0;
    end else begin
      if (ctrl_i.clr) begin
        valid_q <= '0;
      end else if (ctrl_i.we) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (ctrl_i.re) begin
        rvld_q <= valid_q[raddr_i];
        ridx_q <= raddr_i;
      end
    end
  end

  // Effective read data
  assign rval_o  = rvld_q ? $signed(rdata_q[EntryBits-1:RankBits]) : '0;
  assign rrank_o = rvld_q ? rdata_q[RankBits-1:0] : ridx_q;

endmodule

### sim/tb.sv
// Self-checking testbench for the sliding window median filter.
module tb;
  import swmf_pkg::*;

  localparam int RingDepth  = DefMaxWindow;
  localparam int IdleMax    = 11;
  localparam int StuckLimit = 2000;
  localparam int TailCycles = 40;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             window_size_we_i;
  logic        [CfgBits-1:0]        window_size_i;
  logic                             sample_valid_i;
  logic                             sample_stall_o;
  logic signed [DefSampleBits-1:0]  sample_i;
  logic                             median_valid_o;
  logic                             median_stall_i;
  logic signed [DefSampleBits-1:0]  median_o;

  sliding_window_median_filter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .window_size_we_i (window_size_we_i),
    .window_size_i    (window_size_i),
    .sample_valid_i   (sample_valid_i),
    .sample_stall_o   (sample_stall_o),
    .sample_i         (sample_i),
    .median_valid_o   (median_valid_o),
    .median_stall_i   (median_stall_i),
    .median_o         (median_o)
  );

  // Predictor state: our own copy of the window
  logic signed [DefSampleBits-1:0] window_q [RingDepth];
  int unsigned                     win_len;
  int unsigned                     wr_pos;
  logic signed [DefSampleBits-1:0] median_expect_q [$];

  int  err_cnt;
  int  hold_left;
  int  stuck_cnt;
  bit  calm;      // no idling on either side while set
  int  drift;     // slowly moving level for correlated samples

  always #5 clk_i = ~clk_i;

  // Mismatch reporting
  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, IdleMax));
  endfunction

  // Predictor: clear window and set size (0 -> 1, above depth -> depth)
  function automatic void load_window_size(input logic [CfgBits-1:0] val);
    win_len = (val == 0) ? 1 : ((val > RingDepth) ? RingDepth : val);
    for (int i = 0; i < RingDepth; i++) window_q[i] = '0;
    wr_pos = 0;
  endfunction

  // Predictor: store sample, return median of the window
  function automatic logic signed [DefSampleBits-1:0] median_after(
      input logic signed [DefSampleBits-1:0] s);
    logic signed [DefSampleBits-1:0] sorted [RingDepth];
    logic signed [DefSampleBits-1:0] t;
    logic signed [DefSampleBits:0]   sum;
    int j;
    if (wr_pos >= win_len) wr_pos = 0;
    window_q[wr_pos] = s;
    wr_pos++;
    if (wr_pos >= win_len) wr_pos = 0;
    for (int i = 0; i < win_len; i++) sorted[i] = window_q[i];
    // insertion sort over the live entries
    for (int i = 1; i < win_len; i++) begin
      t = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > t) begin
        sorted[j+1] = sorted[j];
        j--;
      end
      sorted[j+1] = t;
    end
    if (win_len % 2 == 1) return sorted[win_len/2];
    sum = sorted[win_len/2 - 1] + sorted[win_len/2];
    return sum[DefSampleBits:1];  // arithmetic halving floors
  endfunction

  // Send one request, then log its expected median
  task automatic send_sample(input logic signed [DefSampleBits-1:0] s);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      sample_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    @(posedge clk_i);
    while (sample_stall_o) @(posedge clk_i);
    median_expect_q.push_back(median_after(s));
  endtask

  // Hold off the sender until every median has come back
  task automatic wait_drain();
    sample_valid_i <= 1'b0;
    while (median_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [CfgBits-1:0] val);
    wait_drain();
    window_size_we_i <= 1'b1;
    window_size_i    <= val;
    @(posedge clk_i);
    window_size_we_i <= 1'b0;
    load_window_size(val);
  endtask

  function automatic logic signed [DefSampleBits-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DefSampleBits'($urandom_range(0, 16'hffff));
      4, 5:       return DefSampleBits'($signed($urandom_range(0, 6)) - 3);  // many ties
      6: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: begin
        drift = drift + int'($urandom_range(0, 200)) - 100;
        if (drift > 32767) drift = 32767;
        if (drift < -32768) drift = -32768;
        return DefSampleBits'(drift);
      end
    endcase
  endfunction

  // Result checking and receiver stall
  always @(posedge clk_i) begin
    if (median_valid_o && !median_stall_i) begin
      if (median_expect_q.size() == 0) begin
        report($sformatf("unexpected median %0d", median_o));
      end else begin
        logic signed [DefSampleBits-1:0] want;
        want = median_expect_q.pop_front();
        if (median_o !== want)
          report($sformatf("median %0d, expected %0d", median_o, want));
      end
      hold_left = draw_gap();
    end else if (median_valid_o && hold_left > 0) begin
      hold_left--;
    end
    median_stall_i <= (hold_left != 0);
  end

  // Watchdog on cycles without any request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || window_size_we_i || (sample_valid_i && !sample_stall_o) ||
        (median_valid_o && !median_stall_i)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= StuckLimit) begin
      $display("watchdog expired at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  // Window of five after reset, early medians see zeros
  task automatic test_reset_window();
    send_sample(16'sd7);
    send_sample(-16'sd9);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
  endtask

  // Even window: floored mean of the middle pair
  task automatic test_even_rounding();
    write_window(5'd2);
    send_sample(-16'sd3);      // with zero: -2
    send_sample(16'sh7fff);
    send_sample(16'sh8000);    // extremes: -1
    send_sample(16'sh8000);
  endtask

  // Size zero saturates to one, oversize to the ring depth
  task automatic test_size_limits();
    write_window(5'd0);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    write_window(5'd17);
    send_sample(-16'sd100);
    send_sample(16'sd100);
    write_window(5'd31);
    send_sample(16'sd1);
    send_sample(-16'sd1);
  endtask

  // Equal values in the window
  task automatic test_ties();
    write_window(5'd4);
    send_sample(16'sd5);
    send_sample(16'sd5);
    send_sample(-16'sd5);
    send_sample(16'sd5);
    send_sample(-16'sd5);
  endtask

  // Sender stops until the pipe is empty, then carries on
  task automatic test_drain_pause();
    write_window(5'd3);
    repeat (3) send_sample(draw_sample());
    wait_drain();
    repeat (3) send_sample(draw_sample());
  endtask

  // Random traffic over a range of window sizes
  task automatic test_random_traffic();
    logic [CfgBits-1:0] sizes [10];
    sizes = '{5'd1, 5'd2, 5'd3, 5'd5, 5'd8, 5'd16, 5'd7, 5'd4, 5'd31, 5'd0};
    for (int ph = 0; ph < 10; ph++) begin
      write_window(ph == 9 ? CfgBits'($urandom_range(0, 31)) : sizes[ph]);
      calm = (ph == 3 || ph == 7);
      for (int k = 0; k < 125; k++) begin
        send_sample(draw_sample());
        if ($urandom_range(0, 99) == 0) wait_drain();
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    window_size_we_i = 1'b0;
    window_size_i    = '0;
    sample_valid_i   = 1'b0;
    sample_i         = '0;
    median_stall_i   = 1'b0;
    err_cnt          = 0;
    hold_left        = 0;
    stuck_cnt        = 0;
    calm             = 1'b0;
    drift            = 0;
    load_window_size(CfgBits'(WindowReset));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_window();
    test_even_rounding();
    test_size_limits();
    test_ties();
    test_drain_pause();
    test_random_traffic();

    wait_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (median_expect_q.size() != 0)
      report($sformatf("%0d medians never arrived", median_expect_q.size()));
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
src/swmf_pkg.sv
src/swmf_ring.sv
src/sliding_window_median_filter.sv
sim/tb.sv
